// File: rtl/fsp_pkg.sv
// Shared constants and types for the Fibonacci-sphere point generator.
`default_nettype none

package fsp_pkg;

    // Golden angle as a 32-bit fraction of a turn
    localparam logic [31:0] GOLDEN_TURN = 32'h61C8_8647;

    // 2*pi in Q32, split into a low word and a small high part
    localparam logic [31:0] TWO_PI_LO = 32'h487E_D511;
    localparam logic [31:0] TWO_PI_HI = 32'd6;

    localparam logic [32:0] Q32_ONE = 33'h1_0000_0000;

    // Horner divisors, highest-order (innermost) term first
    localparam int unsigned SIN_DIV [6] = '{156, 110, 72, 42, 20, 6};
    localparam int unsigned COS_DIV [7] = '{182, 132, 90, 56, 30, 12, 2};

    localparam int HORNER_STAGES = 14;
    // angle mult, fold, radians, square, Horner, quadrant select
    localparam int TRIG_LAT = 4 + HORNER_STAGES + 1;

    typedef enum logic [1:0] {
        QUAD_I   = 2'd0,
        QUAD_II  = 2'd1,
        QUAD_III = 2'd2,
        QUAD_IV  = 2'd3
    } quad_t;

    typedef struct packed {
        logic [32:0] cs;
        logic [32:0] sn;
        logic        cneg;
        logic        sneg;
    } trig_t;

endpackage

`default_nettype wire

// File: rtl/fsp_radius.sv
// Pipelined height divide and ring-radius square root.
`default_nettype none

module fsp_radius
    import fsp_pkg::*;
#(
    parameter int INDEX_WIDTH = 16,
    parameter int FRAC_BITS   = 14
)
(
    input  logic                               clk,
    input  logic                               adv,
    input  logic [INDEX_WIDTH+FRAC_BITS+1:0]   dividend,
    input  logic [INDEX_WIDTH:0]               divisor,
    input  logic                               yneg_in,
    input  logic                               err_in,
    output logic [FRAC_BITS:0]                 root,
    output logic [FRAC_BITS:0]                 quot,
    output logic                               yneg,
    output logic                               err
);

    localparam int QB = FRAC_BITS + 1;
    localparam int RW = INDEX_WIDTH + 2;
    localparam int SW = 2 * FRAC_BITS + 2;
    localparam int RR = FRAC_BITS + 4;

    // restoring divider, one quotient bit per stage
    logic [RW-1:0]          drem_reg [1:QB];
    logic [QB-1:0]          dlow_reg [1:QB];
    logic [QB-1:0]          dquo_reg [1:QB];
    logic [INDEX_WIDTH:0]   ddsr_reg [1:QB];
    logic                   dneg_reg [1:QB];
    logic                   derr_reg [1:QB];

    for (genvar k = 0; k < QB; k++)
    begin : g_div
        logic [RW-1:0]        rem_c;
        logic [QB-1:0]        low_c;
        logic [QB-1:0]        quo_c;
        logic [INDEX_WIDTH:0] dsr_c;
        logic                 neg_c;
        logic                 err_c;
        logic [RW-1:0]        trial;
        logic                 ge;

        if (k == 0)
        begin : g_src
            assign rem_c = RW'(dividend >> QB);
            assign low_c = dividend[QB-1:0];
            assign quo_c = '0;
            assign dsr_c = divisor;
            assign neg_c = yneg_in;
            assign err_c = err_in;
        end
        else
        begin : g_src
            assign rem_c = drem_reg[k];
            assign low_c = dlow_reg[k];
            assign quo_c = dquo_reg[k];
            assign dsr_c = ddsr_reg[k];
            assign neg_c = dneg_reg[k];
            assign err_c = derr_reg[k];
        end

        assign trial = {rem_c[RW-2:0], low_c[QB-1]};
        assign ge    = trial >= RW'(dsr_c);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                drem_reg[k+1] <= ge ? trial - RW'(dsr_c) : trial;
                dlow_reg[k+1] <= {low_c[QB-2:0], 1'b0};
                dquo_reg[k+1] <= {quo_c[QB-2:0], ge};
                ddsr_reg[k+1] <= dsr_c;
                dneg_reg[k+1] <= neg_c;
                derr_reg[k+1] <= err_c;
            end
        end
    end

    // 1 - y^2 in Q(2F)
    logic [SW-1:0]  qsq;
    logic [SW-1:0]  sq_rad_reg;
    logic [QB-1:0]  sq_q_reg;
    logic           sq_neg_reg;
    logic           sq_err_reg;

    assign qsq = SW'(dquo_reg[QB]) * SW'(dquo_reg[QB]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_rad_reg <= (SW'(1) << (2 * FRAC_BITS)) - qsq;
            sq_q_reg   <= dquo_reg[QB];
            sq_neg_reg <= dneg_reg[QB];
            sq_err_reg <= derr_reg[QB];
        end
    end

    // digit-by-digit square root, one root bit per stage
    logic [RR-1:0]  srem_reg  [1:QB];
    logic [QB-1:0]  sroot_reg [1:QB];
    logic [SW-1:0]  srad_reg  [1:QB];
    logic [QB-1:0]  sq_reg    [1:QB];
    logic           sneg_reg  [1:QB];
    logic           serr_reg  [1:QB];

    for (genvar k = 0; k < QB; k++)
    begin : g_sqrt
        logic [RR-1:0] rem_c;
        logic [QB-1:0] root_c;
        logic [SW-1:0] rad_c;
        logic [QB-1:0] q_c;
        logic          neg_c;
        logic          err_c;
        logic [RR-1:0] cur;
        logic [RR-1:0] trial;
        logic          ge;

        if (k == 0)
        begin : g_src
            assign rem_c  = '0;
            assign root_c = '0;
            assign rad_c  = sq_rad_reg;
            assign q_c    = sq_q_reg;
            assign neg_c  = sq_neg_reg;
            assign err_c  = sq_err_reg;
        end
        else
        begin : g_src
            assign rem_c  = srem_reg[k];
            assign root_c = sroot_reg[k];
            assign rad_c  = srad_reg[k];
            assign q_c    = sq_reg[k];
            assign neg_c  = sneg_reg[k];
            assign err_c  = serr_reg[k];
        end

        assign cur   = {rem_c[RR-3:0], rad_c[SW-1:SW-2]};
        assign trial = RR'({root_c, 2'b01});
        assign ge    = cur >= trial;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                srem_reg[k+1]  <= ge ? cur - trial : cur;
                sroot_reg[k+1] <= {root_c[QB-2:0], ge};
                srad_reg[k+1]  <= {rad_c[SW-3:0], 2'b00};
                sq_reg[k+1]    <= q_c;
                sneg_reg[k+1]  <= neg_c;
                serr_reg[k+1]  <= err_c;
            end
        end
    end

    // round to nearest: bump when the remainder exceeds the floor root
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            root <= sroot_reg[QB] + QB'(srem_reg[QB] > RR'(sroot_reg[QB]));
            quot <= sq_reg[QB];
            yneg <= sneg_reg[QB];
            err  <= serr_reg[QB];
        end
    end

endmodule

`default_nettype wire

// File: rtl/fsp_trig.sv
// Pipelined golden-angle azimuth and Q32 sine/cosine.
`default_nettype none

module fsp_trig
    import fsp_pkg::*;
#(
    parameter int INDEX_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   adv,
    input  logic [INDEX_WIDTH-1:0] j,
    output trig_t                  trig
);

    localparam int HS = HORNER_STAGES;

    logic [31:0] a_reg;
    logic [29:0] v_reg;
    logic [1:0]  quad2_reg;
    logic        swap2_reg;
    logic [31:0] x3_reg;
    logic [1:0]  quad3_reg;
    logic        swap3_reg;
    logic [31:0] x4_reg;
    logic [31:0] x2_reg;
    logic [1:0]  quad4_reg;
    logic        swap4_reg;

    logic [29:0] u;
    logic        fold;
    logic [63:0] rad_lo;
    logic [63:0] xsq;

    assign u      = a_reg[29:0];
    assign fold   = u > 30'h2000_0000;
    assign rad_lo = 64'(v_reg) * 64'(TWO_PI_LO);
    assign xsq    = 64'(x3_reg) * 64'(x3_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg     <= 32'(j) * GOLDEN_TURN;
            // fold into the first octant of the quadrant
            v_reg     <= fold ? 30'd0 - u : u;
            quad2_reg <= a_reg[31:30];
            swap2_reg <= fold;
            x3_reg    <= rad_lo[63:32] + 32'(v_reg) * TWO_PI_HI;
            quad3_reg <= quad2_reg;
            swap3_reg <= swap2_reg;
            x4_reg    <= x3_reg;
            x2_reg    <= xsq[63:32];
            quad4_reg <= quad3_reg;
            swap4_reg <= swap3_reg;
        end
    end

    // Horner: even stage *x^2, odd divide-subtract; sine lane ends *x, then holds
    logic [32:0] hs_reg  [1:HS];
    logic [32:0] hc_reg  [1:HS];
    logic [31:0] hx_reg  [1:HS];
    logic [31:0] hx2_reg [1:HS];
    logic [1:0]  hq_reg  [1:HS];
    logic        hsw_reg [1:HS];

    for (genvar k = 0; k < HS; k++)
    begin : g_horner
        logic [32:0] s_c;
        logic [32:0] c_c;
        logic [31:0] x_c;
        logic [31:0] x2_c;
        logic [1:0]  q_c;
        logic        sw_c;
        logic [32:0] s_n;
        logic [32:0] c_n;

        if (k == 0)
        begin : g_src
            assign s_c  = Q32_ONE;
            assign c_c  = Q32_ONE;
            assign x_c  = x4_reg;
            assign x2_c = x2_reg;
            assign q_c  = quad4_reg;
            assign sw_c = swap4_reg;
        end
        else
        begin : g_src
            assign s_c  = hs_reg[k];
            assign c_c  = hc_reg[k];
            assign x_c  = hx_reg[k];
            assign x2_c = hx2_reg[k];
            assign q_c  = hq_reg[k];
            assign sw_c = hsw_reg[k];
        end

        if (k % 2 == 0)
        begin : g_cmul
            logic [64:0] prod;
            assign prod = 65'(x2_c) * 65'(c_c);
            assign c_n  = prod[64:32];
        end
        else
        begin : g_cdiv
            localparam int unsigned DC = COS_DIV[k/2];
            localparam int          LC = $clog2(DC);
            localparam logic [32:0] MC =
                33'(((65'd1 << (32 + LC)) + 65'(DC) - 65'd1) / 65'(DC));
            logic [64:0] prod;
            assign prod = 65'(c_c[31:0]) * 65'(MC);
            assign c_n  = Q32_ONE - 33'(prod >> (32 + LC));
        end

        if (k < 12 && k % 2 == 0)
        begin : g_smul
            logic [64:0] prod;
            assign prod = 65'(x2_c) * 65'(s_c);
            assign s_n  = prod[64:32];
        end
        else if (k < 12)
        begin : g_sdiv
            localparam int unsigned DS = SIN_DIV[k/2];
            localparam int          LS = $clog2(DS);
            localparam logic [32:0] MS =
                33'(((65'd1 << (32 + LS)) + 65'(DS) - 65'd1) / 65'(DS));
            logic [64:0] prod;
            assign prod = 65'(s_c[31:0]) * 65'(MS);
            assign s_n  = Q32_ONE - 33'(prod >> (32 + LS));
        end
        else if (k == 12)
        begin : g_sfin
            logic [64:0] prod;
            assign prod = 65'(x_c) * 65'(s_c);
            assign s_n  = prod[64:32];
        end
        else
        begin : g_shold
            assign s_n = s_c;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                hs_reg[k+1]  <= s_n;
                hc_reg[k+1]  <= c_n;
                hx_reg[k+1]  <= x_c;
                hx2_reg[k+1] <= x2_c;
                hq_reg[k+1]  <= q_c;
                hsw_reg[k+1] <= sw_c;
            end
        end
    end

    logic [32:0] s_oct;
    logic [32:0] c_oct;
    trig_t       sel;

    assign s_oct = hsw_reg[HS] ? hc_reg[HS] : hs_reg[HS];
    assign c_oct = hsw_reg[HS] ? hs_reg[HS] : hc_reg[HS];

    always_comb
    begin
        sel = '0;
        case (quad_t'(hq_reg[HS]))
            QUAD_I:
            begin
                sel.cs = c_oct;
                sel.sn = s_oct;
            end
            QUAD_II:
            begin
                sel.cs   = s_oct;
                sel.cneg = 1'b1;
                sel.sn   = c_oct;
            end
            QUAD_III:
            begin
                sel.cs   = c_oct;
                sel.cneg = 1'b1;
                sel.sn   = s_oct;
                sel.sneg = 1'b1;
            end
            default:
            begin
                sel.cs   = s_oct;
                sel.sn   = c_oct;
                sel.sneg = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            trig <= sel;
        end
    end

endmodule

`default_nettype wire

// File: rtl/fibonacci_sphere_point.sv
// Fibonacci-sphere point generator: top level with handshake and output stage.
//
// Usage: write the set size N on the cfg channel (cfg_data, reset value 1) while
// the block is idle; cfg_ready is always high. Each word on s_axis is a sample
// index; each word on m_axis is the matching point (x, y, z in signed Q1.F) with
// tuser flagging an index at or above N, in which case the coordinates are zero.
// The pipeline depth comes mostly from the bit-per-stage divider and square root
// in series. One index is taken every cycle while the pipeline advances.
// All stages advance together; when m_axis holds a word that is not taken the
// whole pipeline freezes and s_axis_tready drops, so nothing is lost or repeated.
// Reset clears the valid bits and sets N to 1; no words are in flight after it.
`default_nettype none

module fibonacci_sphere_point
    import fsp_pkg::*;
#(
    parameter int INDEX_WIDTH = 16,
    parameter int FRAC_BITS   = 14
)
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        cfg_valid,
    output logic                                        cfg_ready,
    input  logic [INDEX_WIDTH-1:0]                      cfg_data,
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    // sample_index
    input  logic [((INDEX_WIDTH+7)/8)*8-1:0]            s_axis_tdata,
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    // coord_x, coord_y, coord_z
    output logic [((3*(FRAC_BITS+2)+7)/8)*8-1:0]        m_axis_tdata,
    // index_error
    output logic                                        m_axis_tuser
);

    localparam int W     = INDEX_WIDTH;
    localparam int CW    = FRAC_BITS + 2;
    localparam int OW    = ((3 * CW + 7) / 8) * 8;
    localparam int DW    = INDEX_WIDTH + FRAC_BITS + 2;
    localparam int QB    = FRAC_BITS + 1;
    localparam int RLAT  = 2 * FRAC_BITS + 4;
    localparam int ALIGN = RLAT - TRIG_LAT;
    localparam int LAT   = RLAT + 3;
    localparam int PW    = FRAC_BITS + 34;

    logic            adv;
    logic [LAT-1:0]  vld_reg;
    logic [W-1:0]    num_samples_reg;

    assign adv           = !vld_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[LAT-1];
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg         <= '0;
            num_samples_reg <= W'(1);
        end
        else
        begin
            if (adv)
            begin
                vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
            end
            if (cfg_valid)
            begin
                num_samples_reg <= cfg_data;
            end
        end
    end

    // front stage: range check, height numerator, azimuth index
    logic [W-1:0]  idx;
    logic [W+1:0]  numv;
    logic [W+1:0]  numabs;
    logic [W:0]    idx1;

    assign idx    = s_axis_tdata[W-1:0];
    assign numv   = {1'b0, idx, 1'b1} - (W+2)'(num_samples_reg);
    assign numabs = numv[W+1] ? (W+2)'(0) - numv : numv;
    assign idx1   = (W+1)'(idx) + (W+1)'(1);

    logic           r1_err_reg;
    logic           r1_yneg_reg;
    logic [DW-1:0]  r1_dvd_reg;
    logic [W:0]     r1_dsr_reg;
    logic [W-1:0]   r1_j_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r1_err_reg  <= idx >= num_samples_reg;
            r1_yneg_reg <= numv[W+1];
            r1_dvd_reg  <= (DW'(numabs[W-1:0]) << QB) + DW'(num_samples_reg);
            r1_dsr_reg  <= {num_samples_reg, 1'b0};
            // the last point wraps to angle zero
            r1_j_reg    <= (idx1 == (W+1)'(num_samples_reg)) ? '0 : idx1[W-1:0];
        end
    end

    logic [FRAC_BITS:0] rad_root;
    logic [FRAC_BITS:0] rad_q;
    logic               rad_yneg;
    logic               rad_err;
    trig_t              trig_out;

    fsp_radius #(
        .INDEX_WIDTH (INDEX_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_radius (
        .clk      (clk),
        .adv      (adv),
        .dividend (r1_dvd_reg),
        .divisor  (r1_dsr_reg),
        .yneg_in  (r1_yneg_reg),
        .err_in   (r1_err_reg),
        .root     (rad_root),
        .quot     (rad_q),
        .yneg     (rad_yneg),
        .err      (rad_err)
    );

    fsp_trig #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_trig (
        .clk  (clk),
        .adv  (adv),
        .j    (r1_j_reg),
        .trig (trig_out)
    );

    // line the trig words up with the radius path
    trig_t trig_dly_reg [0:ALIGN-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            trig_dly_reg[0] <= trig_out;
            for (int k = 1; k < ALIGN; k++)
            begin
                trig_dly_reg[k] <= trig_dly_reg[k-1];
            end
        end
    end

    trig_t               al;
    logic [PW-1:0]       px_reg;
    logic [PW-1:0]       pz_reg;
    logic                m_cneg_reg;
    logic                m_sneg_reg;
    logic [FRAC_BITS:0]  m_q_reg;
    logic                m_yneg_reg;
    logic                m_err_reg;

    assign al = trig_dly_reg[ALIGN-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg     <= PW'(rad_root) * PW'(al.cs) + (PW'(1) << 31);
            pz_reg     <= PW'(rad_root) * PW'(al.sn) + (PW'(1) << 31);
            m_cneg_reg <= al.cneg;
            m_sneg_reg <= al.sneg;
            m_q_reg    <= rad_q;
            m_yneg_reg <= rad_yneg;
            m_err_reg  <= rad_err;
        end
    end

    logic [CW-1:0] mx;
    logic [CW-1:0] mz;
    logic [CW-1:0] my;
    logic [CW-1:0] out_x_reg;
    logic [CW-1:0] out_y_reg;
    logic [CW-1:0] out_z_reg;
    logic          out_err_reg;

    assign mx = px_reg[PW-1:32];
    assign mz = pz_reg[PW-1:32];
    assign my = CW'(m_q_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_x_reg   <= m_err_reg ? '0 : (m_cneg_reg ? CW'(0) - mx : mx);
            out_y_reg   <= m_err_reg ? '0 : (m_yneg_reg ? CW'(0) - my : my);
            out_z_reg   <= m_err_reg ? '0 : (m_sneg_reg ? CW'(0) - mz : mz);
            out_err_reg <= m_err_reg;
        end
    end

    assign m_axis_tdata = OW'({out_z_reg, out_y_reg, out_x_reg});
    assign m_axis_tuser = out_err_reg;

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> vld_reg[0])
        else $error("accepted index did not enter the pipeline");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("out-of-range index gave nonzero coordinates");

endmodule

`default_nettype wire

// File: tb/fibonacci_sphere_point_tb.sv
// Testbench for the Fibonacci-sphere point generator: predictor and scoreboard.
`timescale 1ns / 1ps

module fibonacci_sphere_point_tb
    import fsp_pkg::*;
();

    localparam int IW = 16;
    localparam int FB = 14;
    localparam int CW = FB + 2;
    localparam int LATENCY = 2 * FB + 7;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
        logic          err;
    } point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [IW-1:0] cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic m_axis_tuser;

    fibonacci_sphere_point dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always #10 clk = ~clk;

    point_t expected_points[$];
    logic [IW-1:0] set_size;
    int mismatches = 0;
    bit stim_done = 1'b0;
    bit hold_off = 1'b0;

    function automatic logic [63:0] isqrt_round(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        if (v > res) res++;
        return res;
    endfunction

    function automatic void octant_sincos(logic [63:0] v, output logic [63:0] s,
                                          output logic [63:0] c);
        logic [63:0] xr, x2, t;
        int sdiv[6] = '{156, 110, 72, 42, 20, 6};
        int cdiv[7] = '{182, 132, 90, 56, 30, 12, 2};
        logic [127:0] p;
        p = v * 128'h6487ED511;
        xr = p[95:32];
        p = xr * xr;
        x2 = p[95:32];
        t = 64'd1 << 32;
        for (int k = 0; k < 6; k++)
        begin
            p = x2 * t;
            t = (64'd1 << 32) - (p[95:32] / sdiv[k]);
        end
        p = xr * t;
        s = p[95:32];
        t = 64'd1 << 32;
        for (int k = 0; k < 7; k++)
        begin
            p = x2 * t;
            t = (64'd1 << 32) - (p[95:32] / cdiv[k]);
        end
        c = t;
    endfunction

    function automatic logic [CW-1:0] scale_coord(logic [63:0] r, logic [63:0] mag, bit neg);
        logic [127:0] p;
        logic [63:0] m;
        p = r * mag + (128'd1 << 31);
        m = p[95:32];
        return neg ? -m[CW-1:0] : m[CW-1:0];
    endfunction

    function automatic point_t sphere_point(logic [IW-1:0] idx, logic [IW-1:0] n);
        point_t pt;
        longint num;
        logic [63:0] mag, q, r, s, c, cs, sn, u;
        logic [31:0] a, step;
        bit yneg, cneg, sneg;
        quad_t quad;
        pt = '0;
        if (idx >= n)
        begin
            pt.err = 1'b1;
            return pt;
        end
        num = longint'(2 * idx + 1) - longint'(n);
        yneg = num < 0;
        mag = yneg ? -num : num;
        q = ((mag << (FB + 1)) + n) / (2 * n);
        pt.y = yneg ? -q[CW-1:0] : q[CW-1:0];
        r = isqrt_round((64'd1 << (2 * FB)) - q * q);
        step = (32'(idx) + 1 == 32'(n)) ? 32'd0 : 32'(idx) + 1;
        a = step * GOLDEN_TURN;
        quad = quad_t'(a[31:30]);
        u = 64'(a[29:0]);
        if (u > (64'd1 << 29))
            octant_sincos((64'd1 << 30) - u, c, s);
        else
            octant_sincos(u, s, c);
        case (quad)
            QUAD_I:   begin cs = c; cneg = 0; sn = s; sneg = 0; end
            QUAD_II:  begin cs = s; cneg = 1; sn = c; sneg = 0; end
            QUAD_III: begin cs = c; cneg = 1; sn = s; sneg = 1; end
            default:  begin cs = s; cneg = 0; sn = c; sneg = 1; end
        endcase
        pt.x = scale_coord(r, cs, cneg);
        pt.z = scale_coord(r, sn, sneg);
        return pt;
    endfunction

    // directed rows: index, load flag and set size to write first, known result if given
    typedef struct {
        logic [IW-1:0] idx;
        bit            load;
        logic [IW-1:0] n;
        bit            known;
        point_t        pt;
    } row_t;

    row_t dir_rows[] = '{
        '{16'd0,     0, 16'd0,     1, '{16'h4000, 16'd0, 16'd0, 1'b0}},
        '{16'd1,     0, 16'd0,     1, '{16'd0, 16'd0, 16'd0, 1'b1}},
        '{16'hFFFF,  0, 16'd0,     1, '{16'd0, 16'd0, 16'd0, 1'b1}},
        '{16'd0,     1, 16'd0,     1, '{16'd0, 16'd0, 16'd0, 1'b1}},
        '{16'hFFFF,  0, 16'd0,     1, '{16'd0, 16'd0, 16'd0, 1'b1}},
        '{16'd0,     1, 16'd2,     0, '0},
        '{16'd1,     0, 16'd0,     0, '0},
        '{16'd2,     0, 16'd0,     1, '{16'd0, 16'd0, 16'd0, 1'b1}},
        '{16'd0,     1, 16'hFFFF,  0, '0},
        '{16'd1,     0, 16'd0,     0, '0},
        '{16'h7FFF,  0, 16'd0,     0, '0},
        '{16'h8000,  0, 16'd0,     0, '0},
        '{16'hFFFE,  0, 16'd0,     0, '0},
        '{16'hFFFF,  0, 16'd0,     1, '{16'd0, 16'd0, 16'd0, 1'b1}},
        '{16'd0,     1, 16'd7,     0, '0},
        '{16'd3,     0, 16'd0,     0, '0},
        '{16'd6,     0, 16'd0,     0, '0},
        '{16'd5,     0, 16'd0,     0, '0}
    };

    task automatic wait_cycles(int n);
        repeat (n) @(posedge clk);
    endtask

    task automatic write_set_size(logic [IW-1:0] n);
        s_axis_tvalid <= 1'b0;
        wait (expected_points.size() == 0);
        wait_cycles(LATENCY + 4);
        cfg_valid <= 1'b1;
        cfg_data <= n;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        set_size = n;
    endtask

    // tvalid stays up between back-to-back words; this task drops it only before a gap
    task automatic send_index(logic [IW-1:0] idx, bit known, point_t pt);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            wait_cycles(gap);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= idx;
        do @(posedge clk); while (!s_axis_tready);
        expected_points.push_back(known ? pt : sphere_point(idx, set_size));
    endtask

    function automatic logic [IW-1:0] pick_index(logic [IW-1:0] n);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return IW'($urandom());
        if (sel == 1) return n;
        if (n == 0) return IW'($urandom());
        return IW'($urandom_range(0, n - 1));
    endfunction

    initial
    begin
        logic [IW-1:0] sizes[6];
        sizes = '{16'd1, 16'd13, 16'd256, 16'd1000, 16'hFFFF, 16'h5A3C};
        set_size = 1;
        wait_cycles(9);
        rst_n <= 1'b1;
        wait_cycles(2);
        foreach (dir_rows[k])
        begin
            if (dir_rows[k].load) write_set_size(dir_rows[k].n);
            send_index(dir_rows[k].idx, dir_rows[k].known, dir_rows[k].pt);
        end
        for (int ph = 0; ph < 8; ph++)
        begin
            write_set_size(ph < 6 ? sizes[ph] : 16'($urandom()));
            if (ph == 2) hold_off = 1'b1;
            for (int k = 0; k < 110; k++)
                send_index(pick_index(set_size), 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver: random stalls plus one long hold-off
    initial
    begin
        int gap;
        wait (rst_n);
        forever
        begin
            if (hold_off)
            begin
                hold_off = 1'b0;
                m_axis_tready <= 1'b0;
                wait_cycles(200);
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (gap != 0)
            begin
                m_axis_tready <= 1'b0;
                wait_cycles(gap);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge clk)
    begin
        point_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[CW-1:0], m_axis_tdata[2*CW-1:CW],
                   m_axis_tdata[3*CW-1:2*CW], m_axis_tuser};
            if (expected_points.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", got);
            end
            else
            begin
                want = expected_points.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp x=%h y=%h z=%h err=%b got x=%h y=%h z=%h err=%b",
                                 want.x, want.y, want.z, want.err,
                                 got.x, got.y, got.z, got.err);
                end
            end
        end
    end

    initial
    begin
        wait (stim_done);
        wait (expected_points.size() == 0);
        wait_cycles(LATENCY + 10);
        if (mismatches == 0)
            $display("[fibonacci_sphere_point] OK");
        else
            $display("[fibonacci_sphere_point] ERROR");
        $finish;
    end

    initial
    begin
        #4ms;
        $display("[fibonacci_sphere_point] ERROR");
        $finish;
    end
endmodule
